// ===== rtl/assert_macros.svh =====
// Assertion helpers for the video unit register port.
// Both sample on aclk and are held off while aresetn is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every sampled edge.
`define VURP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Condition must never be seen.
`define VURP_NEVER(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) !(cond)) else $error(msg);

`endif

// ===== rtl/vurp_pkg.sv =====
package vurp_pkg;

    // request kinds carried in s_tuser
    typedef enum logic [1:0] {
        REQ_READ  = 2'd0,
        REQ_WRITE = 2'd1,
        REQ_TICK  = 2'd2
    } req_t;

    // register numbers
    localparam logic [2:0] REG_CTRL     = 3'd0;
    localparam logic [2:0] REG_MASK     = 3'd1;
    localparam logic [2:0] REG_STATUS   = 3'd2;
    localparam logic [2:0] REG_OAM_ADDR = 3'd3;
    localparam logic [2:0] REG_OAM_DATA = 3'd4;
    localparam logic [2:0] REG_SCROLL   = 3'd5;
    localparam logic [2:0] REG_ADDR     = 3'd6;
    localparam logic [2:0] REG_DATA     = 3'd7;

    // raster timing
    localparam int DOTS_PER_LINE   = 341;
    localparam int LINES_PER_FRAME = 262;
    localparam int VBLANK_LINE     = 241;

    localparam int NAME_RAM_DEPTH_DEF = 4096;

    localparam logic [5:0]  PAL_PAGE     = 6'h3F;
    localparam logic [4:0]  PAL_MIRROR_M = 5'h13;
    localparam logic [4:0]  PAL_MIRROR_V = 5'h10;

    typedef enum logic [1:0] {
        ST_CLEAR = 2'b01,
        ST_RUN   = 2'b10
    } state_t;

    // sprite-color mirrors fold onto the background entries
    function automatic logic [4:0] palette_slot(input logic [4:0] a);
        logic [4:0] s;
        s = a;
        if ((a & PAL_MIRROR_M) == PAL_MIRROR_V) begin
            s = {1'b0, a[3:0]};
        end
        return s;
    endfunction

endpackage

// ===== rtl/video_unit_register_port.sv =====
// CPU-side register port of a simplified picture unit. Each input transaction is a
// register read, a register write or one dot tick (kind in s_tuser); each produces
// exactly one result transaction carrying the read byte and the NMI / frame-done
// pulses. One transaction is taken per clock, sustained while m_tready is high: the
// work of an item sits between an input register and the result register, and the
// input register lets one more item in while a result waits on m_tready. After reset
// the name-table RAM (NAME_RAM_DEPTH entries, 4096 by default) is swept to zero, one
// entry per cycle, and s_tready stays low until the sweep is done. Reads of the data
// register are buffered as usual: the byte returned is the one fetched by the previous
// data read. Pattern-table space reads as zero and ignores writes; palette mirrors fold
// onto the background entries.
`include "assert_macros.svh"

module video_unit_register_port #(
    parameter int NAME_RAM_DEPTH = vurp_pkg::NAME_RAM_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [2:0] reg_address, [10:3] write_data, rest zero
    input  logic [1:0]  s_tuser,   // [1:0] req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // [7:0] read_data, [8] nmi_pulse, [9] frame_done
);

    localparam int NT_AW = $clog2(NAME_RAM_DEPTH);

    // ---------------------------------------------------------------- state
    vurp_pkg::state_t state_reg, state_next;
    logic [NT_AW-1:0] clr_cnt_reg, clr_cnt_next;

    // input register
    logic        in_valid_reg, in_valid_next;
    logic [1:0]  in_type_reg;
    logic [2:0]  in_regno_reg;
    logic [7:0]  in_data_reg;

    // result register
    logic        m_valid_reg, m_valid_next;
    logic [7:0]  out_data_reg, out_data_next;
    logic        out_nmi_reg, out_nmi_next;
    logic        out_fd_reg, out_fd_next;
    logic        out_spr_sel_reg, out_spr_sel_next;   // read byte comes from sprite RAM

    // programmer-visible registers
    logic [7:0]  ctrl_reg, ctrl_next;
    logic        vblank_reg, vblank_next;
    logic [7:0]  spr_addr_reg, spr_addr_next;
    logic [7:0]  read_buffer_reg, read_buffer_next;
    logic        buf_src_reg, buf_src_next;           // 1: buffer lives in nt_rdata_reg
    logic [15:0] video_addr_reg, video_addr_next;
    logic [14:0] temp_addr_reg, temp_addr_next;
    logic        toggle_reg, toggle_next;
    logic [8:0]  line_reg, line_next;
    logic [8:0]  dot_reg, dot_next;

    // stores
    logic [7:0]  name_mem [NAME_RAM_DEPTH];
    logic [7:0]  nt_rdata_reg;
    logic [7:0]  spr_mem [256];
    logic [7:0]  spr_rdata_reg;
    logic        spr_rvalid_reg;
    logic [255:0] spr_valid_reg;
    logic [7:0]  palette_reg [32];

    // ------------------------------------------------------------ handshake
    logic out_free, proc, s_accept;

    assign out_free = !m_valid_reg || m_tready;
    assign proc     = in_valid_reg && out_free;
    assign s_tready = (state_reg == vurp_pkg::ST_RUN) && (!in_valid_reg || out_free);
    assign s_accept = s_tvalid && s_tready;

    // ------------------------------------------------------- address decode
    logic [13:0]      va14;
    logic             va_pattern, va_palette, va_name;
    logic [12:0]      nt_a12, nt_sub;
    logic [NT_AW-1:0] nt_idx;
    logic [4:0]       pal_slot;
    logic [7:0]       pal_q;
    logic [7:0]       buf_value;
    logic [15:0]      addr_step;

    assign va14       = video_addr_reg[13:0];
    assign va_pattern = !va14[13];
    assign va_palette = (va14[13:8] == vurp_pkg::PAL_PAGE);
    assign va_name    = !va_pattern && !va_palette;

    // modulo by the RAM depth with one subtraction: correct only while the index is below twice the depth
    assign nt_a12 = {1'b0, va14[11:0]};
    assign nt_sub = nt_a12 - 13'(NAME_RAM_DEPTH);
    assign nt_idx = (nt_a12 >= 13'(NAME_RAM_DEPTH)) ? nt_sub[NT_AW-1:0] : nt_a12[NT_AW-1:0];

    assign pal_slot  = vurp_pkg::palette_slot(va14[4:0]);
    assign pal_q     = palette_reg[pal_slot];
    assign buf_value = buf_src_reg ? nt_rdata_reg : read_buffer_reg;
    assign addr_step = ctrl_reg[2] ? 16'd32 : 16'd1;

    // ---------------------------------------------------------- raster step
    logic [9:0] dot_inc, line_inc;
    logic       dot_wrap;

    assign dot_inc  = {1'b0, dot_reg} + 10'd1;
    assign dot_wrap = ({1'b0, dot_inc[8:0]} >= 10'(vurp_pkg::DOTS_PER_LINE))
                      || (dot_inc[8:0] == 9'd0);
    assign line_inc = {1'b0, line_reg} + 10'd1;

    // ---------------------------------------------------------- item logic
    logic nt_rd_en, nt_wr_en, pal_wr_en, spr_wr_en, spr_rd_en;

    always_comb begin
        ctrl_next        = ctrl_reg;
        vblank_next      = vblank_reg;
        spr_addr_next    = spr_addr_reg;
        read_buffer_next = read_buffer_reg;
        buf_src_next     = buf_src_reg;
        video_addr_next  = video_addr_reg;
        temp_addr_next   = temp_addr_reg;
        toggle_next      = toggle_reg;
        line_next        = line_reg;
        dot_next         = dot_reg;
        out_data_next    = 8'h00;
        out_nmi_next     = 1'b0;
        out_fd_next      = 1'b0;
        out_spr_sel_next = 1'b0;
        nt_rd_en         = 1'b0;
        nt_wr_en         = 1'b0;
        pal_wr_en        = 1'b0;
        spr_wr_en        = 1'b0;
        spr_rd_en        = 1'b0;

        if (proc) begin
            unique case (in_type_reg)
                vurp_pkg::REQ_READ: begin
                    unique case (in_regno_reg)
                        vurp_pkg::REG_STATUS: begin
                            out_data_next = {vblank_reg, 7'b0};
                            vblank_next   = 1'b0;
                            toggle_next   = 1'b0;
                        end
                        vurp_pkg::REG_OAM_DATA: begin
                            spr_rd_en        = 1'b1;
                            out_spr_sel_next = 1'b1;
                        end
                        vurp_pkg::REG_DATA: begin
                            out_data_next   = buf_value;
                            video_addr_next = video_addr_reg + addr_step;
                            if (va_name) begin
                                nt_rd_en     = 1'b1;
                                buf_src_next = 1'b1;
                            end else begin
                                buf_src_next     = 1'b0;
                                read_buffer_next = va_palette ? pal_q : 8'h00;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                vurp_pkg::REQ_WRITE: begin
                    unique case (in_regno_reg)
                        vurp_pkg::REG_CTRL: begin
                            ctrl_next      = in_data_reg;
                            temp_addr_next = {temp_addr_reg[14:12], in_data_reg[1:0],
                                              temp_addr_reg[9:0]};
                        end
                        vurp_pkg::REG_MASK: begin
                        end
                        vurp_pkg::REG_STATUS: begin
                        end
                        vurp_pkg::REG_OAM_ADDR: begin
                            spr_addr_next = in_data_reg;
                        end
                        vurp_pkg::REG_OAM_DATA: begin
                            spr_wr_en     = 1'b1;
                            spr_addr_next = spr_addr_reg + 8'd1;
                        end
                        vurp_pkg::REG_SCROLL: begin
                            if (!toggle_reg) begin
                                temp_addr_next = {temp_addr_reg[14:5], in_data_reg[7:3]};
                            end else begin
                                temp_addr_next = {in_data_reg[2:0], temp_addr_reg[11:10],
                                                  in_data_reg[7:3], temp_addr_reg[4:0]};
                            end
                            toggle_next = !toggle_reg;
                        end
                        vurp_pkg::REG_ADDR: begin
                            if (!toggle_reg) begin
                                temp_addr_next = {1'b0, in_data_reg[5:0], temp_addr_reg[7:0]};
                            end else begin
                                temp_addr_next  = {temp_addr_reg[14:8], in_data_reg};
                                video_addr_next = {1'b0, temp_addr_reg[14:8], in_data_reg};
                            end
                            toggle_next = !toggle_reg;
                        end
                        vurp_pkg::REG_DATA: begin
                            nt_wr_en        = va_name;
                            pal_wr_en       = va_palette;
                            video_addr_next = video_addr_reg + addr_step;
                        end
                    endcase
                end
                vurp_pkg::REQ_TICK: begin
                    dot_next = dot_inc[8:0];
                    if (dot_wrap) begin
                        dot_next = 9'd0;
                        if (line_inc == 10'(vurp_pkg::VBLANK_LINE)) begin
                            line_next    = line_inc[8:0];
                            vblank_next  = 1'b1;
                            out_nmi_next = ctrl_reg[7];
                            out_fd_next  = 1'b1;
                        end else if (line_inc >= 10'(vurp_pkg::LINES_PER_FRAME)) begin
                            line_next   = 9'd0;
                            vblank_next = 1'b0;
                        end else begin
                            line_next = line_inc[8:0];
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // --------------------------------------------------- clearing sequencer
    always_comb begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        unique case (state_reg)
            vurp_pkg::ST_CLEAR: begin
                if (clr_cnt_reg == NT_AW'(NAME_RAM_DEPTH - 1)) begin
                    state_next = vurp_pkg::ST_RUN;
                end else begin
                    clr_cnt_next = clr_cnt_reg + 1'b1;
                end
            end
            vurp_pkg::ST_RUN: begin
            end
        endcase
    end

    // ---------------------------------------------------- handshake state
    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_accept) begin
            in_valid_next = 1'b1;
        end else if (proc) begin
            in_valid_next = 1'b0;
        end
        m_valid_next = m_valid_reg;
        if (proc) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    // ---------------------------------------------------------- registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= vurp_pkg::ST_CLEAR;
            clr_cnt_reg     <= '0;
            in_valid_reg    <= 1'b0;
            m_valid_reg     <= 1'b0;
            ctrl_reg        <= 8'h00;
            vblank_reg      <= 1'b0;
            spr_addr_reg    <= 8'h00;
            read_buffer_reg <= 8'h00;
            buf_src_reg     <= 1'b0;
            video_addr_reg  <= 16'h0000;
            temp_addr_reg   <= 15'h0000;
            toggle_reg      <= 1'b0;
            line_reg        <= 9'd0;
            dot_reg         <= 9'd0;
            spr_valid_reg   <= '0;
            for (int i = 0; i < 32; i++) begin
                palette_reg[i] <= 8'h00;
            end
        end else begin
            state_reg       <= state_next;
            clr_cnt_reg     <= clr_cnt_next;
            in_valid_reg    <= in_valid_next;
            m_valid_reg     <= m_valid_next;
            ctrl_reg        <= ctrl_next;
            vblank_reg      <= vblank_next;
            spr_addr_reg    <= spr_addr_next;
            read_buffer_reg <= read_buffer_next;
            buf_src_reg     <= buf_src_next;
            video_addr_reg  <= video_addr_next;
            temp_addr_reg   <= temp_addr_next;
            toggle_reg      <= toggle_next;
            line_reg        <= line_next;
            dot_reg         <= dot_next;
            if (spr_wr_en) begin
                spr_valid_reg[spr_addr_reg] <= 1'b1;
            end
            if (pal_wr_en) begin
                palette_reg[pal_slot] <= in_data_reg;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_type_reg  <= s_tuser;
            in_regno_reg <= s_tdata[2:0];
            in_data_reg  <= s_tdata[10:3];
        end
        if (proc) begin
            out_data_reg    <= out_data_next;
            out_nmi_reg     <= out_nmi_next;
            out_fd_reg      <= out_fd_next;
            out_spr_sel_reg <= out_spr_sel_next;
        end
    end

    // name-table RAM: clear sweep or data-port write, one buffered read
    always_ff @(posedge aclk) begin
        if (state_reg == vurp_pkg::ST_CLEAR) begin
            name_mem[clr_cnt_reg] <= 8'h00;
        end else if (nt_wr_en) begin
            name_mem[nt_idx] <= in_data_reg;
        end
        if (nt_rd_en) begin
            nt_rdata_reg <= name_mem[nt_idx];
        end
    end

    // sprite RAM; entries never written read as zero through the valid bits
    always_ff @(posedge aclk) begin
        if (spr_wr_en) begin
            spr_mem[spr_addr_reg] <= in_data_reg;
        end
        if (spr_rd_en) begin
            spr_rdata_reg  <= spr_mem[spr_addr_reg];
            spr_rvalid_reg <= spr_valid_reg[spr_addr_reg];
        end
    end

    // ------------------------------------------------------------ outputs
    logic [7:0] rd_out;

    assign rd_out   = out_spr_sel_reg ? (spr_rvalid_reg ? spr_rdata_reg : 8'h00)
                                      : out_data_reg;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'b0, out_fd_reg, out_nmi_reg, rd_out};

    // ---------------------------------------------------------- assertions
    `VURP_NEVER(a_no_accept_in_clear, (state_reg == vurp_pkg::ST_CLEAR) && s_tready, "accept during RAM clear")
    `VURP_ASSERT(a_input_held, (in_valid_reg && !out_free) |=> in_valid_reg, "stalled item dropped")
    `VURP_ASSERT(a_proc_gives_result, proc |=> m_valid_reg, "processed item produced no result")
    `VURP_ASSERT(a_nmi_with_frame, (m_valid_reg && out_nmi_reg) |-> out_fd_reg, "NMI without frame done")

endmodule
